// ===== rtl/core/bbnd_pkg.sv =====
// Shared constants and types for the BGGR nearest-neighbor demosaic unit.
package bbnd_pkg;

  localparam int CFG_W    = 13;
  localparam int CMP_W    = CFG_W + 1;
  localparam int SAMPLE_W = 12;
  localparam int COLOR_W  = 8;
  localparam int PIX_W    = 12;
  localparam int TOP_W    = 2 * COLOR_W;

  localparam int DEF_MAX_LINE_WIDTH   = 4096;
  localparam int DEF_MAX_FRAME_HEIGHT = 4096;

  localparam logic [CFG_W-1:0] LINE_WIDTH_RESET   = 13'd4056;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = 13'd3040;

  localparam logic REG_LINE_WIDTH   = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green_top;
    logic [COLOR_W-1:0] green_bottom;
    logic [COLOR_W-1:0] blue;
    logic [PIX_W-1:0]   column;
    logic [PIX_W-1:0]   row;
  } cell_t;

endpackage

// ===== rtl/core/bbnd_cell_store.sv =====
// Position counters, top-row store memory and completed-cell register.
module bbnd_cell_store import bbnd_pkg::*; #(
  parameter int MAX_LINE_WIDTH   = DEF_MAX_LINE_WIDTH,
  parameter int MAX_FRAME_HEIGHT = DEF_MAX_FRAME_HEIGHT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [CFG_W-1:0]    line_width,
  input  logic [CFG_W-1:0]    frame_height,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [SAMPLE_W-1:0] raw_sample,
  input  logic                frame_start,
  output logic                cell_valid,
  output cell_t               cell_data,
  input  logic                cell_take
);

  localparam int CW          = $clog2(MAX_LINE_WIDTH);
  localparam int RW          = $clog2(MAX_FRAME_HEIGHT);
  localparam int STORE_DEPTH = MAX_LINE_WIDTH / 2;
  localparam int AW          = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  logic [TOP_W-1:0] mem [STORE_DEPTH];

  logic [CW-1:0]      column_count;
  logic [RW-1:0]      row_count;
  logic [COLOR_W-1:0] bottom_left_green;
  logic               s1_valid;

  logic [TOP_W-1:0]   rd_q;
  logic [COLOR_W-1:0] red_q;
  logic [COLOR_W-1:0] gbot_q;
  logic [PIX_W-1:0]   col_q;
  logic [PIX_W-1:0]   row_q;

  logic [CW-1:0]       c_cur;
  logic [RW-1:0]       r_cur;
  logic [CW-1:0]       column_count_next;
  logic [RW-1:0]       row_count_next;
  logic [CW-2:0]       slot;
  logic [AW-1:0]       addr;
  logic                in_range;
  logic                accept;
  logic                emit;
  logic [COLOR_W-1:0]  s;
  logic [CMP_W-1:0]    w_eff;
  logic [CMP_W-1:0]    h_eff;
  logic [CMP_W-1:0]    c_inc;
  logic [CMP_W-1:0]    r_inc;
  logic [CW+PIX_W-1:0] col_ext;
  logic [RW+PIX_W-1:0] row_ext;

  assign in_ready = !s1_valid || cell_take;
  assign accept   = in_valid && in_ready;

  assign s     = raw_sample[SAMPLE_W-1:SAMPLE_W-COLOR_W];
  assign c_cur = frame_start ? '0 : column_count;
  assign r_cur = frame_start ? '0 : row_count;
  assign slot  = c_cur[CW-1:1];
  assign addr  = slot[AW-1:0];
  assign in_range = CMP_W'(slot) < CMP_W'(STORE_DEPTH);
  assign emit  = in_range && r_cur[0] && c_cur[0];

  always_comb begin
    if (CMP_W'(line_width) > CMP_W'(MAX_LINE_WIDTH)) begin
      w_eff = CMP_W'(MAX_LINE_WIDTH);
    end else if (line_width == '0) begin
      w_eff = CMP_W'(1);
    end else begin
      w_eff = CMP_W'(line_width);
    end
    if (CMP_W'(frame_height) > CMP_W'(MAX_FRAME_HEIGHT)) begin
      h_eff = CMP_W'(MAX_FRAME_HEIGHT);
    end else if (frame_height == '0) begin
      h_eff = CMP_W'(1);
    end else begin
      h_eff = CMP_W'(frame_height);
    end
    c_inc = CMP_W'(c_cur) + CMP_W'(1);
    r_inc = CMP_W'(r_cur) + CMP_W'(1);
    column_count_next = c_inc[CW-1:0];
    row_count_next    = r_cur;
    if (c_inc >= w_eff) begin
      column_count_next = '0;
      row_count_next    = (r_inc >= h_eff) ? '0 : r_inc[RW-1:0];
    end
  end

  assign col_ext = (CW+PIX_W)'(c_cur);
  assign row_ext = (RW+PIX_W)'(r_cur);

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count      <= '0;
      row_count         <= '0;
      bottom_left_green <= '0;
      s1_valid          <= 1'b0;
    end else begin
      if (cell_take) begin
        s1_valid <= 1'b0;
      end
      if (accept) begin
        column_count <= column_count_next;
        row_count    <= row_count_next;
        if (in_range && r_cur[0] && !c_cur[0]) begin
          bottom_left_green <= s;
        end
        if (emit) begin
          s1_valid <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_range && !r_cur[0]) begin
      if (!c_cur[0]) begin
        mem[addr][COLOR_W-1:0] <= s;
      end else begin
        mem[addr][TOP_W-1:COLOR_W] <= s;
      end
    end
    if (accept && emit) begin
      rd_q   <= mem[addr];
      red_q  <= s;
      gbot_q <= bottom_left_green;
      col_q  <= col_ext[PIX_W-1:0];
      row_q  <= row_ext[PIX_W-1:0];
    end
  end

  assign cell_valid              = s1_valid;
  assign cell_data.red           = red_q;
  assign cell_data.green_top     = rd_q[TOP_W-1:COLOR_W];
  assign cell_data.green_bottom  = gbot_q;
  assign cell_data.blue          = rd_q[COLOR_W-1:0];
  assign cell_data.column        = col_q;
  assign cell_data.row           = row_q;

endmodule

// ===== rtl/core/bbnd_pixel_emit.sv =====
// Output register that sends the four pixels of a completed cell.
module bbnd_pixel_emit import bbnd_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cell_valid,
  input  cell_t                     cell_data,
  output logic                      cell_take,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [3*COLOR_W+2*PIX_W-1:0] m_tdata,
  output logic                      m_tlast
);

  localparam logic [1:0] LAST_IDX = 2'd3;

  logic       em_valid;
  logic [1:0] idx;
  cell_t      cell_q;

  logic [COLOR_W-1:0] green;
  logic [PIX_W-1:0]   column;
  logic [PIX_W-1:0]   row;
  logic               last;

  assign last      = idx == LAST_IDX;
  assign cell_take = cell_valid && (!em_valid || (m_tready && last));

  always_ff @(posedge clk) begin
    if (rst) begin
      em_valid <= 1'b0;
      idx      <= '0;
    end else if (cell_take) begin
      em_valid <= 1'b1;
      idx      <= '0;
    end else if (em_valid && m_tready) begin
      if (last) begin
        em_valid <= 1'b0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cell_take) begin
      cell_q <= cell_data;
    end
  end

  assign green  = idx[1] ? cell_q.green_bottom : cell_q.green_top;
  assign column = idx[0] ? cell_q.column : cell_q.column - PIX_W'(1);
  assign row    = idx[1] ? cell_q.row : cell_q.row - PIX_W'(1);

  assign m_tvalid = em_valid;
  assign m_tdata  = {row, column, cell_q.blue, green, cell_q.red};
  assign m_tlast  = last;

endmodule

// ===== rtl/core/bayer_bggr_nearest_demosaic_unit.sv =====
// Top level of the BGGR nearest-neighbor demosaic unit with its register port.
// Raw 12-bit BGGR samples enter in raster order; each red sample (odd row,
// odd column) completes a 2x2 cell and yields four RGB pixels, top-left,
// top-right, bottom-left, bottom-right, the last one flagged by m_tlast.
// Each red sample and its top-row store read are registered in the cell
// store, and the cell then moves into the output register before its first
// pixel leaves. The single output channel sends one pixel per cycle while
// m_tready is high; odd lines stall input while a completed cell waits for
// it, and even lines run at one sample per cycle unless a cell still waits.
// Registers: line_width at 0x0, frame_height at 0x4.
module bayer_bggr_nearest_demosaic_unit import bbnd_pkg::*; #(
  parameter int MAX_LINE_WIDTH   = DEF_MAX_LINE_WIDTH,
  parameter int MAX_FRAME_HEIGHT = DEF_MAX_FRAME_HEIGHT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [11:0] raw_sample
  input  logic        s_tuser,   // frame_start
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // red, green, blue, pixel_column, pixel_row
  output logic        m_tlast    // last_of_cell
);

  logic [CFG_W-1:0] line_width;
  logic [CFG_W-1:0] frame_height;
  logic             cell_valid;
  logic             cell_take;
  cell_t            cell_data;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width   <= LINE_WIDTH_RESET;
      frame_height <= FRAME_HEIGHT_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        REG_LINE_WIDTH:   line_width   <= pwdata[CFG_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= pwdata[CFG_W-1:0];
        default:          line_width   <= line_width;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_LINE_WIDTH:   prdata = 32'(line_width);
      REG_FRAME_HEIGHT: prdata = 32'(frame_height);
      default:          prdata = '0;
    endcase
  end

  bbnd_cell_store #(
    .MAX_LINE_WIDTH   (MAX_LINE_WIDTH),
    .MAX_FRAME_HEIGHT (MAX_FRAME_HEIGHT)
  ) u_store (
    .clk          (clk),
    .rst          (rst),
    .line_width   (line_width),
    .frame_height (frame_height),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .raw_sample   (s_tdata[SAMPLE_W-1:0]),
    .frame_start  (s_tuser),
    .cell_valid   (cell_valid),
    .cell_data    (cell_data),
    .cell_take    (cell_take)
  );

  bbnd_pixel_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .cell_valid (cell_valid),
    .cell_data  (cell_data),
    .cell_take  (cell_take),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast)
  );

endmodule
